// File: rtl/polar_min_range_binner_macros.svh
// assertion macros used by the pmrb_ctrl module
// each expects clk and rst_n to be visible at the point of use
`ifndef POLAR_MIN_RANGE_BINNER_MACROS_SVH
`define POLAR_MIN_RANGE_BINNER_MACROS_SVH

// same-cycle implication
`define PMRB_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pmrb assertion failed");

// next-cycle implication
`define PMRB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pmrb assertion failed");

`endif

// File: rtl/pmrb_pkg.sv
`default_nettype none
package pmrb_pkg;

    localparam int ANGLE_ITERS = 19;
    localparam int ANGLE_W     = 20;
    localparam int STEP_W      = 19;
    localparam int RANGE_W     = 16;
    localparam int BINS_W      = 13;
    localparam int BIN_NUM_W   = 12;
    localparam int ENTRY_W     = 17;
    localparam int Z_W         = 22;
    localparam int Q_W         = 22;
    localparam int DEN_W       = 20;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int HALF_TURN   = 524288;

    // register indexes
    localparam logic [2:0] REG_ANGLE_LOW  = 3'd0;
    localparam logic [2:0] REG_ANGLE_HIGH = 3'd1;
    localparam logic [2:0] REG_ANGLE_STEP = 3'd2;
    localparam logic [2:0] REG_RANGE_LOW  = 3'd3;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd4;
    localparam logic [2:0] REG_BINS_USED  = 3'd5;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_low;
        logic signed [ANGLE_W-1:0] angle_high;
        logic [STEP_W-1:0]         angle_step;
        logic [RANGE_W-1:0]        range_low;
        logic [RANGE_W-1:0]        range_high;
        logic [BINS_W-1:0]         bins_used;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic sq_a;
        logic sq_b;
        logic iter;
        logic check;
        logic div_step;
        logic bin_rd;
        logic acc_wr;
        logic rb_rd;
        logic rb_clr;
        logic clr_wr;
        logic out_load;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic keep;
        logic bin_ok;
    } sts_t;

    // atan(2^-i) in units of pi/2^19
    function automatic logic [17:0] atan_unit(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd131072;
            5'd1:    v = 18'd77376;
            5'd2:    v = 18'd40884;
            5'd3:    v = 18'd20753;
            5'd4:    v = 18'd10417;
            5'd5:    v = 18'd5213;
            5'd6:    v = 18'd2607;
            5'd7:    v = 18'd1304;
            5'd8:    v = 18'd652;
            5'd9:    v = 18'd326;
            5'd10:   v = 18'd163;
            5'd11:   v = 18'd81;
            5'd12:   v = 18'd41;
            5'd13:   v = 18'd20;
            5'd14:   v = 18'd10;
            5'd15:   v = 18'd5;
            5'd16:   v = 18'd3;
            5'd17:   v = 18'd1;
            5'd18:   v = 18'd1;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/pmrb_cmd_if.sv
`default_nettype none
interface pmrb_cmd_if import pmrb_pkg::*; #(
    parameter int COORD_BITS = 17
) ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [BIN_NUM_W-1:0]         read_bin;

    modport source (output valid, output mode, output point_x, output point_y,
                    output read_bin, input ready);
    modport sink (input valid, input mode, input point_x, input point_y,
                  input read_bin, output ready);
endinterface
`default_nettype wire

// File: rtl/pmrb_rsp_if.sv
`default_nettype none
interface pmrb_rsp_if import pmrb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BIN_NUM_W-1:0] bin_number;
    logic [RANGE_W-1:0]   bin_range;
    logic                 bin_hit;

    modport source (output valid, output bin_number, output bin_range,
                    output bin_hit, input ready);
    modport sink (input valid, input bin_number, input bin_range,
                  input bin_hit, output ready);
endinterface
`default_nettype wire

// File: rtl/pmrb_ram.sv
`default_nettype none
module pmrb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/pmrb_cfg.sv
`default_nettype none
module pmrb_cfg import pmrb_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output cfg_t                   cfg
);
    cfg_t       cfg_reg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_low  <= 20'sh80000;
            cfg_reg.angle_high <= 20'sh7FFFF;
            cfg_reg.angle_step <= 19'd291;
            cfg_reg.range_low  <= 16'd50;
            cfg_reg.range_high <= 16'd25000;
            cfg_reg.bins_used  <= 13'd3601;
        end
        else if (wr)
        begin
            case (idx)
                REG_ANGLE_LOW:  cfg_reg.angle_low  <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_HIGH: cfg_reg.angle_high <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_STEP: cfg_reg.angle_step <= pwdata[STEP_W-1:0];
                REG_RANGE_LOW:  cfg_reg.range_low  <= pwdata[RANGE_W-1:0];
                REG_RANGE_HIGH: cfg_reg.range_high <= pwdata[RANGE_W-1:0];
                REG_BINS_USED:  cfg_reg.bins_used  <= pwdata[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_ANGLE_LOW:  prdata = {12'd0, cfg_reg.angle_low};
            REG_ANGLE_HIGH: prdata = {12'd0, cfg_reg.angle_high};
            REG_ANGLE_STEP: prdata = {13'd0, cfg_reg.angle_step};
            REG_RANGE_LOW:  prdata = {16'd0, cfg_reg.range_low};
            REG_RANGE_HIGH: prdata = {16'd0, cfg_reg.range_high};
            REG_BINS_USED:  prdata = {19'd0, cfg_reg.bins_used};
            default:        prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/pmrb_ctrl.sv
`default_nettype none
module pmrb_ctrl import pmrb_pkg::*; #(
    parameter int NUM_BINS   = 4096,
    parameter int COORD_BITS = 17,
    localparam int AW = $clog2(NUM_BINS),
    localparam int CW = (AW > 6) ? AW : 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_mode,
    output logic               in_ready,
    input  wire logic          out_ready,
    output logic               out_valid,
    input  wire sts_t          sts,
    output ctl_t               ctl,
    output logic [CW-1:0]      cnt
);
`include "polar_min_range_binner_macros.svh"

    localparam int NI = (COORD_BITS > ANGLE_ITERS) ? COORD_BITS : ANGLE_ITERS;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SQ_A   = 4'd2;
    localparam logic [3:0] S_SQ_B   = 4'd3;
    localparam logic [3:0] S_ITER   = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_BIN    = 4'd7;
    localparam logic [3:0] S_ACC    = 4'd8;
    localparam logic [3:0] S_RB_RD  = 4'd9;
    localparam logic [3:0] S_RB_CLR = 4'd10;
    localparam logic [3:0] S_RB_OUT = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign cnt       = cnt_reg;

    // state, counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ctl            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_BINS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = in_mode ? S_RB_RD : S_SQ_A;
                end
            end
            S_SQ_A:
            begin
                ctl.sq_a   = 1'b1;
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                ctl.sq_b   = 1'b1;
                cnt_next   = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                ctl.iter = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NI - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.check  = 1'b1;
                cnt_next   = '0;
                state_next = sts.keep ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(Q_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                ctl.bin_rd = sts.bin_ok;
                state_next = sts.bin_ok ? S_ACC : S_IDLE;
            end
            S_ACC:
            begin
                ctl.acc_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_RB_RD:
            begin
                ctl.rb_rd  = 1'b1;
                state_next = S_RB_CLR;
            end
            S_RB_CLR:
            begin
                ctl.rb_clr = 1'b1;
                state_next = S_RB_OUT;
            end
            S_RB_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    `PMRB_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE)
    `PMRB_ASSERT_IMPL(a_out_no_overwrite, ctl.out_load, !out_valid_reg || out_ready)
    `PMRB_ASSERT_IMPL(a_iter_bound, state_reg == S_ITER, cnt_reg < CW'(NI))
    `PMRB_ASSERT_NEXT(a_clear_done, state_reg == S_CLEAR && cnt_reg == CW'(NUM_BINS - 1),
        state_reg == S_IDLE)
endmodule
`default_nettype wire

// File: rtl/pmrb_datapath.sv
`default_nettype none
module pmrb_datapath import pmrb_pkg::*; #(
    parameter int NUM_BINS   = 4096,
    parameter int COORD_BITS = 17,
    localparam int AW = $clog2(NUM_BINS),
    localparam int CW = (AW > 6) ? AW : 6
) (
    input  wire logic                         clk,
    input  wire ctl_t                         ctl,
    input  wire logic [CW-1:0]                cnt,
    input  wire cfg_t                         cfg,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic [BIN_NUM_W-1:0]         read_bin,
    output sts_t                              sts,
    output logic [BIN_NUM_W-1:0]              bin_number,
    output logic [RANGE_W-1:0]                bin_range,
    output logic                              bin_hit
);
    localparam int C  = COORD_BITS;
    localparam int SW = 2 * C;
    localparam int RW = C + 2;
    localparam int XW = C + 14;
    localparam int EW = (C + 1 > 17) ? C + 1 : 17;

    // captured item
    logic signed [C-1:0]  x_reg, y_reg;
    logic [C-1:0]         ax_reg, ay_reg;
    logic [BIN_NUM_W-1:0] rbin_reg;
    logic [C-1:0]         xu, yu;

    // range and angle units
    logic [SW-1:0]        prod_reg;
    logic [SW-1:0]        sq_s_reg;
    logic [RW-1:0]        rem_reg;
    logic [C-1:0]         root_reg;
    logic signed [XW-1:0] cx_reg, cy_reg;
    logic signed [Z_W-1:0] z_reg;
    logic                 zero_reg;
    logic [RANGE_W-1:0]   r_reg;

    // divider
    logic [Q_W-1:0]       div_num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     div_rem_reg;
    logic [Q_W-1:0]       q_reg;

    // output register
    logic [BIN_NUM_W-1:0] bin_number_reg;
    logic [RANGE_W-1:0]   bin_range_reg;
    logic                 bin_hit_reg;

    // memory
    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [ENTRY_W-1:0]   wr_data, rd_data;

    assign xu = point_x;
    assign yu = point_y;

    // capture an accepted transaction
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg    <= point_x;
            y_reg    <= point_y;
            ax_reg   <= xu[C-1] ? (~xu + C'(1)) : xu;
            ay_reg   <= yu[C-1] ? (~yu + C'(1)) : yu;
            rbin_reg <= read_bin;
        end
    end

    // squared length and cordic seed
    logic signed [XW-1:0] xs, ys;
    assign xs = XW'(x_reg) <<< 12;
    assign ys = XW'(y_reg) <<< 12;

    // sqrt digit step
    logic [RW-1:0] sq_remw, sq_trial;
    assign sq_remw  = {rem_reg[RW-3:0], sq_s_reg[SW-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};

    // cordic step
    logic signed [XW-1:0] cdx, cdy;
    logic [4:0]           ci;
    logic [17:0]          tab;
    assign ci  = cnt[4:0];
    assign cdx = cy_reg >>> ci;
    assign cdy = cx_reg >>> ci;
    assign tab = atan_unit(ci);

    always_ff @(posedge clk)
    begin
        if (ctl.sq_a)
        begin
            prod_reg <= SW'(ax_reg * ax_reg);
            zero_reg <= (x_reg == '0) && (y_reg == '0);
            if (x_reg < 0)
            begin
                cx_reg <= -xs;
                cy_reg <= -ys;
                z_reg  <= (y_reg >= 0) ? Z_W'(HALF_TURN) : -Z_W'(HALF_TURN);
            end
            else
            begin
                cx_reg <= xs;
                cy_reg <= ys;
                z_reg  <= '0;
            end
        end
        if (ctl.sq_b)
        begin
            sq_s_reg <= prod_reg + SW'(ay_reg * ay_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (ctl.iter)
        begin
            if (cnt < CW'(C))
            begin
                sq_s_reg <= {sq_s_reg[SW-3:0], 2'b00};
                if (sq_remw >= sq_trial)
                begin
                    rem_reg  <= sq_remw - sq_trial;
                    root_reg <= {root_reg[C-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_remw;
                    root_reg <= {root_reg[C-2:0], 1'b0};
                end
            end
            if (cnt < CW'(ANGLE_ITERS))
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + cdx;
                    cy_reg <= cy_reg - cdy;
                    z_reg  <= z_reg + Z_W'(tab);
                end
                else
                begin
                    cx_reg <= cx_reg - cdx;
                    cy_reg <= cy_reg + cdy;
                    z_reg  <= z_reg - Z_W'(tab);
                end
            end
        end
    end

    // window check and divider setup
    logic [C:0]                r_full;
    logic [EW-1:0]             r_ext;
    logic signed [ANGLE_W-1:0] ang;
    logic signed [ANGLE_W:0]   dif;
    logic [STEP_W-1:0]         step1;
    logic                      range_ok, angle_ok;

    assign r_full   = {1'b0, root_reg} + ((rem_reg > RW'(root_reg)) ? (C+1)'(1) : '0);
    assign r_ext    = EW'(r_full);
    assign range_ok = (r_ext >= EW'(cfg.range_low)) && (r_ext <= EW'(cfg.range_high));
    assign ang      = zero_reg ? '0 : z_reg[ANGLE_W-1:0];
    assign angle_ok = (ang >= cfg.angle_low) && (ang <= cfg.angle_high);
    assign dif      = (ANGLE_W+1)'(ang) - (ANGLE_W+1)'(cfg.angle_low);
    assign step1    = (cfg.angle_step == '0) ? STEP_W'(1) : cfg.angle_step;
    assign sts.keep = range_ok && angle_ok;

    // restoring division step
    logic [DEN_W:0] dv_remw;
    logic           dv_ge;
    assign dv_remw = {div_rem_reg, div_num_reg[Q_W-1]};
    assign dv_ge   = dv_remw >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.check)
        begin
            r_reg       <= r_full[RANGE_W-1:0];
            div_num_reg <= {1'b0, dif[ANGLE_W-1:0], 1'b0} + {3'b000, step1};
            den_reg     <= {step1, 1'b0};
            div_rem_reg <= '0;
            q_reg       <= '0;
        end
        if (ctl.div_step)
        begin
            div_num_reg <= {div_num_reg[Q_W-2:0], 1'b0};
            div_rem_reg <= dv_ge ? DEN_W'(dv_remw - {1'b0, den_reg}) : dv_remw[DEN_W-1:0];
            q_reg       <= {q_reg[Q_W-2:0], dv_ge};
        end
    end

    // bin limits and store access
    logic [31:0] q_ext, rb_ext;
    logic        rb_in;
    logic        update;
    assign q_ext      = 32'(q_reg);
    assign rb_ext     = 32'(rbin_reg);
    assign rb_in      = rb_ext < 32'(NUM_BINS);
    assign sts.bin_ok = (q_ext < 32'(cfg.bins_used)) && (q_ext < 32'(NUM_BINS));
    assign update     = !rd_data[ENTRY_W-1] || (r_reg < rd_data[RANGE_W-1:0]);

    always_comb
    begin
        rd_en   = ctl.bin_rd || ctl.rb_rd;
        rd_addr = ctl.rb_rd ? rb_ext[AW-1:0] : q_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = cnt[AW-1:0];
        wr_data = '0;
        if (ctl.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.acc_wr)
        begin
            wr_en   = update;
            wr_addr = q_reg[AW-1:0];
            wr_data = {1'b1, r_reg};
        end
        else if (ctl.rb_clr)
        begin
            wr_en   = rb_in;
            wr_addr = rb_ext[AW-1:0];
        end
    end

    pmrb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register
    logic hit_now;
    assign hit_now = rb_in && rd_data[ENTRY_W-1];

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            bin_number_reg <= rbin_reg;
            bin_hit_reg    <= hit_now;
            bin_range_reg  <= hit_now ? rd_data[RANGE_W-1:0] : '0;
        end
    end

    assign bin_number = bin_number_reg;
    assign bin_range  = bin_range_reg;
    assign bin_hit    = bin_hit_reg;
endmodule
`default_nettype wire

// File: rtl/polar_min_range_binner.sv
// polar_min_range_binner: angular bins keeping the nearest 2-D point
//
// cmd channel (valid/ready): mode 0 carries a point (point_x, point_y in mm),
// mode 1 reads bin read_bin and clears it. rsp channel returns one transaction
// per read (bin_number, bin_range, bin_hit); points return none. the user
// writes registers over the apb port while the block is idle; not enforced.
//
// for a point the sqrt and cordic share one iteration counter (one root bit
// and one rotation per cycle), then the restoring bin divider runs, then, for a
// point inside the window and bins_used, one store read-modify-write follows.
// a read steps through store read, clear and load of the result register,
// the load waiting for a free output register, before cmd ready returns.
// one transaction is in work at a time; cmd ready is high only when idle.
//
// after reset the store is cleared one bin a cycle, all NUM_BINS bins, with
// cmd ready low. when rsp is stalled a pending result holds in the output
// register; points keep being accepted, a further read waits for it.
`default_nettype none
module polar_min_range_binner import pmrb_pkg::*; #(
    parameter int NUM_BINS   = 4096,
    parameter int COORD_BITS = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    pmrb_cmd_if.sink               cmd,
    pmrb_rsp_if.source             rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);
    localparam int AW = $clog2(NUM_BINS);
    localparam int CW = (AW > 6) ? AW : 6;

    cfg_t          cfg;
    ctl_t          ctl;
    sts_t          sts;
    logic [CW-1:0] cnt;
    logic          in_ready, out_valid;

    assign cmd.ready = in_ready;
    assign rsp.valid = out_valid;

    // configuration registers
    pmrb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    pmrb_ctrl #(
        .NUM_BINS   (NUM_BINS),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_mode   (cmd.mode),
        .in_ready  (in_ready),
        .out_ready (rsp.ready),
        .out_valid (out_valid),
        .sts       (sts),
        .ctl       (ctl),
        .cnt       (cnt)
    );

    // datapath
    pmrb_datapath #(
        .NUM_BINS   (NUM_BINS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .ctl        (ctl),
        .cnt        (cnt),
        .cfg        (cfg),
        .point_x    (cmd.point_x),
        .point_y    (cmd.point_y),
        .read_bin   (cmd.read_bin),
        .sts        (sts),
        .bin_number (rsp.bin_number),
        .bin_range  (rsp.bin_range),
        .bin_hit    (rsp.bin_hit)
    );
endmodule
`default_nettype wire

// File: bench/polar_min_range_binner_tb.sv
`default_nettype none
module polar_min_range_binner_tb;
    import pmrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS       = 4096;
    localparam int CBITS       = 17;
    localparam int POINT_LAT   = 60;
    localparam int STALL_LIMIT = 20000;
    localparam int ATAN_STEPS[ANGLE_ITERS] = '{131072, 77376, 40884, 20753, 10417, 5213,
        2607, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

    typedef enum logic {OP_POINT = 1'b0, OP_READ = 1'b1} op_e;

    typedef struct {
        logic [BIN_NUM_W-1:0] bin_number;
        logic [RANGE_W-1:0]   bin_range;
        logic                 bin_hit;
    } bin_read_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    pmrb_cmd_if #(.COORD_BITS(CBITS)) cmd_ch ();
    pmrb_rsp_if rsp_ch ();

    polar_min_range_binner #(.NUM_BINS(NBINS), .COORD_BITS(CBITS)) dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the block's registers and bin store
    int             cfg_angle_low, cfg_angle_high;
    int             cfg_angle_step, cfg_range_low, cfg_range_high, cfg_bins_used;
    logic [16:0]    bin_mem [NBINS];
    int             filled_bins[$];
    bin_read_t      bin_reads_due[$];

    int  fail_count = 0;
    int  points_sent = 0, reads_sent = 0, hits_seen = 0, reads_seen = 0;
    int  burst_left = 0;
    int  recv_stall_pct = 30;
    int  hold_cycles = 0;
    int  idle_cycles = 0;

    function automatic longint nearest_root(longint s);
        longint rem, res, b;
        rem = s;
        res = 0;
        b = longint'(1) << 34;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        if (s - res * res > res)
            res++;
        return res;
    endfunction

    function automatic int cordic_angle(longint x, longint y);
        longint cx, cy, z, dx, dy;
        int     w;
        if (x == 0 && y == 0)
            return 0;
        z = 0;
        cx = x * 4096;
        cy = y * 4096;
        if (x < 0)
        begin
            cx = -cx;
            cy = -cy;
            z = (y >= 0) ? 524288 : -524288;
        end
        for (int i = 0; i < ANGLE_ITERS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx += dx;
                cy -= dy;
                z += ATAN_STEPS[i];
            end
            else
            begin
                cx -= dx;
                cy += dy;
                z -= ATAN_STEPS[i];
            end
        end
        w = int'(z & 64'hFFFFF);
        if (w >= HALF_TURN)
            w -= 2 * HALF_TURN;
        return w;
    endfunction

    // fold one point into the shadow store
    function automatic void bin_point(int x, int y);
        longint r, d, b, stp;
        int     a;
        r = nearest_root(longint'(x) * x + longint'(y) * y);
        stp = (cfg_angle_step == 0) ? 1 : cfg_angle_step;
        if (r < cfg_range_low || r > cfg_range_high)
            return;
        a = cordic_angle(x, y);
        if (a < cfg_angle_low || a > cfg_angle_high)
            return;
        d = a - cfg_angle_low;
        b = (2 * d + stp) / (2 * stp);
        if (b >= cfg_bins_used || b >= NBINS)
            return;
        if (!bin_mem[b][16] || r < bin_mem[b][15:0])
        begin
            bin_mem[b] = {1'b1, 16'(r)};
            filled_bins.push_back(int'(b));
            if (filled_bins.size() > 64)
                void'(filled_bins.pop_front());
        end
    endfunction

    function automatic void read_and_clear(int b);
        bin_read_t e;
        e.bin_number = BIN_NUM_W'(b);
        e.bin_hit = bin_mem[b][16];
        e.bin_range = bin_mem[b][16] ? bin_mem[b][15:0] : '0;
        bin_mem[b] = '0;
        bin_reads_due.push_back(e);
    endfunction

    // one command transaction, with burst and gap pacing
    task automatic send_item(op_e op, int x, int y, int b);
        if (burst_left == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= op;
        cmd_ch.point_x  <= CBITS'(x);
        cmd_ch.point_y  <= CBITS'(y);
        cmd_ch.read_bin <= BIN_NUM_W'(b);
        do @(posedge clk); while (!cmd_ch.ready);
        if (op == OP_POINT)
        begin
            points_sent++;
            bin_point(x, y);
        end
        else
        begin
            reads_sent++;
            read_and_clear(b);
        end
    endtask

    task automatic send_point(int x, int y);
        send_item(OP_POINT, x, y, $urandom_range(0, NBINS - 1));
    endtask

    task automatic send_read(int b);
        send_item(OP_READ, $urandom_range(0, 131071) - 65536,
                  $urandom_range(0, 131071) - 65536, b);
    endtask

    task automatic read_filled();
        if (filled_bins.size() != 0 && $urandom_range(0, 4) != 0)
            send_read(filled_bins[$urandom_range(0, filled_bins.size() - 1)]);
        else
            send_read($urandom_range(0, NBINS - 1));
    endtask

    // let everything in flight finish before touching registers
    task automatic wait_idle();
        burst_left = 0;
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (bin_reads_due.size() != 0)
            @(posedge clk);
        repeat (POINT_LAT) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ANGLE_LOW:  cfg_angle_low  = int'(signed'(value[ANGLE_W-1:0]));
            REG_ANGLE_HIGH: cfg_angle_high = int'(signed'(value[ANGLE_W-1:0]));
            REG_ANGLE_STEP: cfg_angle_step = int'(value[STEP_W-1:0]);
            REG_RANGE_LOW:  cfg_range_low  = int'(value[RANGE_W-1:0]);
            REG_RANGE_HIGH: cfg_range_high = int'(value[RANGE_W-1:0]);
            REG_BINS_USED:  cfg_bins_used  = int'(value[BINS_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(int alo, int ahi, int stp, int rlo, int rhi, int nb);
        wait_idle();
        reg_write(REG_ANGLE_LOW, DATA_W'(alo));
        reg_write(REG_ANGLE_HIGH, DATA_W'(ahi));
        reg_write(REG_ANGLE_STEP, DATA_W'(stp));
        reg_write(REG_RANGE_LOW, DATA_W'(rlo));
        reg_write(REG_RANGE_HIGH, DATA_W'(rhi));
        reg_write(REG_BINS_USED, DATA_W'(nb));
    endtask

    // random coordinates, mostly inside the usual range window
    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2:    return $urandom_range(0, 600) - 300;
            3:          return $urandom_range(0, 131071) - 65536;
            default:    return $urandom_range(0, 40000) - 20000;
        endcase
    endfunction

    task automatic random_traffic(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                read_filled();
            else
                send_point(pick_coord(), pick_coord());
        end
    endtask

    // extremes of the coordinates, pi wrap, zero vector, axes
    task automatic test_directed();
        send_point(0, 0);
        send_point(65535, 0);
        send_point(-65536, 0);
        send_point(-1000, 0);
        send_point(-1000, -1);
        send_point(0, 65535);
        send_point(0, -65536);
        send_point(-65536, -65536);
        send_point(65535, 65535);
        send_point(1000, 1000);
        send_point(900, 1000);
        send_point(30, 30);
        send_point(-20000, 1);
        send_point(25000, 0);
        send_point(25001, 0);
        send_point(0, 50);
        send_point(0, 49);
        for (int i = 0; i < 6 && filled_bins.size() != 0; i++)
            send_read(filled_bins.pop_back());
        send_read(0);
        send_read(NBINS - 1);
    endtask

    task automatic test_window_extremes();
        // narrow angle window, unit step
        set_config(-1000, 1000, 1, 0, 65535, 4096);
        for (int i = 0; i < 120; i++)
            send_point($urandom_range(1000, 60000), $urandom_range(0, 4000) - 2000);
        random_traffic(150);
        // zero step, full window, bins_used past the store
        set_config(-HALF_TURN, HALF_TURN - 1, 0, 0, 65535, 8191);
        random_traffic(150);
        // widest step: only bins 0 and 1
        set_config(-HALF_TURN, HALF_TURN - 1, 524287, 0, 65535, 2);
        random_traffic(80);
        for (int b = 0; b < 3; b++)
            send_read(b);
        // nothing may land
        set_config(-HALF_TURN, HALF_TURN - 1, 291, 50, 25000, 0);
        random_traffic(60);
        set_config(5000, -5000, 291, 50, 25000, 3601);
        random_traffic(60);
        set_config(-HALF_TURN, HALF_TURN - 1, 291, 30000, 100, 3601);
        random_traffic(60);
        // single bin
        set_config(-HALF_TURN, HALF_TURN - 1, 1, 0, 65535, 1);
        random_traffic(60);
    endtask

    task automatic test_random(int n);
        set_config(-HALF_TURN, HALF_TURN - 1, 291, 50, 25000, 3601);
        recv_stall_pct = 0;
        random_traffic(n / 3);
        set_config(-200000, 300000, 97, 10, 40000, 4096);
        recv_stall_pct = 50;
        random_traffic(n / 3);
        set_config($urandom_range(0, 400000) - 524288, $urandom_range(0, 400000),
                   $urandom_range(50, 3000), $urandom_range(0, 200),
                   $urandom_range(20000, 65535), $urandom_range(1, 4096));
        recv_stall_pct = 20;
        random_traffic(n / 3);
    endtask

    // receiver blocks while reads keep coming, so the command side backs up
    task automatic test_backpressure();
        wait_idle();
        hold_cycles = 500;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 3 == 0)
                read_filled();
            else
                send_point(pick_coord(), pick_coord());
        end
    endtask

    // receiver pacing
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        bin_read_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            reads_seen++;
            if (rsp_ch.bin_hit)
                hits_seen++;
            if (bin_reads_due.size() == 0)
            begin
                fail_count++;
                $error("unexpected bin read transaction, bin_number %0d", rsp_ch.bin_number);
            end
            else
            begin
                e = bin_reads_due.pop_front();
                if (rsp_ch.bin_number !== e.bin_number)
                begin
                    fail_count++;
                    $error("bin_number: expected %0d, got %0d", e.bin_number,
                           rsp_ch.bin_number);
                end
                if (rsp_ch.bin_range !== e.bin_range)
                begin
                    fail_count++;
                    $error("bin_range: expected %0d, got %0d", e.bin_range, rsp_ch.bin_range);
                end
                if (rsp_ch.bin_hit !== e.bin_hit)
                begin
                    fail_count++;
                    $error("bin_hit: expected %0d, got %0d", e.bin_hit, rsp_ch.bin_hit);
                end
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        cmd_ch.valid    <= 1'b0;
        cmd_ch.mode     <= OP_POINT;
        cmd_ch.point_x  <= '0;
        cmd_ch.point_y  <= '0;
        cmd_ch.read_bin <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        cfg_angle_low  = -HALF_TURN;
        cfg_angle_high = HALF_TURN - 1;
        cfg_angle_step = 291;
        cfg_range_low  = 50;
        cfg_range_high = 25000;
        cfg_bins_used  = 3601;
        foreach (bin_mem[i])
            bin_mem[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_window_extremes();
        test_random(1050);
        test_backpressure();

        wait_idle();
        $display("covered %0d points and %0d bin reads (%0d with a return)",
                 points_sent, reads_sent, hits_seen);
        $display("checked %0d read transactions across several register settings",
                 reads_seen);
        if (fail_count == 0 && bin_reads_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
